/* rtl/afsrt_pkg.sv */
// ----------------------------------------------------------------------------
// afsrt_pkg : shared types and constants of the SRT matrix builder
// Fixed-point widths, the matrix transaction type and the arctangent steps.
// ----------------------------------------------------------------------------
package afsrt_pkg;

  localparam int Q_W  = 32;  // Q16.16 entry width
  localparam int SC_W = 18;  // rounded sine and cosine, Q2.16
  localparam int CD_W = 34;  // CORDIC datapath, Q2.30 with headroom

  localparam logic signed [Q_W-1:0] ONE_Q16  = 32'sd65536;
  localparam logic        [1:0]     LAST_ROW = 2'd3;

  typedef logic signed [SC_W-1:0] trig_t;
  typedef logic signed [CD_W-1:0] cd_t;

  // rot: scaled rotation rows 0..2, columns 0..2; mv: translation row
  typedef struct packed {
    logic [2:0][2:0][Q_W-1:0] rot;
    logic [2:0][Q_W-1:0]      mv;
  } mat_t;

  localparam logic [31:0] ATAN_TAB [10] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149
  };

  // atan(2^-i) in Q2.30
  function automatic cd_t atan_q30(input int unsigned i);
    cd_t a;
    a = '0;
    if (i < 10) begin
      a = cd_t'(ATAN_TAB[i[3:0]]);
    end else if (i <= 30) begin
      a = cd_t'(64'd1 << (30 - i));
    end
    return a;
  endfunction

endpackage

/* rtl/affine_srt_matrix_builder_unit.sv */
// ----------------------------------------------------------------------------
// affine_srt_matrix_builder_unit : scale-rotate-translate 4x4 matrix builder
// Pipelined angle reduction, CORDIC sine/cosine and matrix assembly.
// ----------------------------------------------------------------------------
// Input channel: one transaction carries scale, Euler angles and translation,
// all signed Q16.16; it is taken on a clock edge with in_valid_i high and
// in_stall_o low. Output channel: four transactions per input, rows 0 to 3,
// row 3 flagged by last_row_o; taken when out_valid_o is high and out_stall_i
// low.
// Pipeline: 4 reduction stages, CORDIC_STEPS rotation stages, 1 rounding stage,
// 3 matrix stages, then the row buffer, from which rows 0 to 3 leave in order.
// Throughput is set by the single output row port, four rows per input; the
// pipeline takes a new input every cycle until a finished matrix waits in its
// last stage for the buffer.
// Reset clears the valid bits and the row sequencer; the pipeline is empty.
// When the receiver stalls, the current row holds, the pipeline freezes as a
// whole once its last stage holds a matrix waiting for the buffer, and
// in_stall_o is raised.
module affine_srt_matrix_builder_unit
  import afsrt_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [Q_W-1:0] scale_x_i,
  input  logic [Q_W-1:0] scale_y_i,
  input  logic [Q_W-1:0] scale_z_i,
  input  logic [Q_W-1:0] angle_x_i,
  input  logic [Q_W-1:0] angle_y_i,
  input  logic [Q_W-1:0] angle_z_i,
  input  logic [Q_W-1:0] move_x_i,
  input  logic [Q_W-1:0] move_y_i,
  input  logic [Q_W-1:0] move_z_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     row_index_o,
  output logic [Q_W-1:0] entry_0_o,
  output logic [Q_W-1:0] entry_1_o,
  output logic [Q_W-1:0] entry_2_o,
  output logic [Q_W-1:0] entry_3_o,
  output logic           last_row_o
);

  // total pipeline depth, and the delay until the sines are ready
  localparam int LAT = CORDIC_STEPS + 8;
  localparam int DLY = CORDIC_STEPS + 5;

  logic [LAT-1:0]      vld_q;
  logic                en, take;
  logic [2:0][Q_W-1:0] ang, sc_in, mv_in;
  logic [2:0][Q_W-1:0] sc_dl_q [DLY];
  logic [2:0][Q_W-1:0] mv_dl_q [DLY];
  cd_t                 z_w   [3];
  logic                neg_w [3];
  trig_t               sin_w [3];
  trig_t               cos_w [3];
  mat_t                mat;

  // freeze the whole pipeline while its last stage waits for the buffer
  assign en         = !vld_q[LAT-1] || take;
  assign in_stall_o = !en;

  assign ang   = {angle_z_i, angle_y_i, angle_x_i};
  assign sc_in = {scale_z_i, scale_y_i, scale_x_i};
  assign mv_in = {move_z_i, move_y_i, move_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // scale and translation ride alongside the angle lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_dl_q[0] <= sc_in;
      mv_dl_q[0] <= mv_in;
      for (int k = 1; k < DLY; k++) begin
        sc_dl_q[k] <= sc_dl_q[k-1];
        mv_dl_q[k] <= mv_dl_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    afsrt_angle_red u_red (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (ang[l]),
      .z_o     (z_w[l]),
      .neg_o   (neg_w[l])
    );

    afsrt_cordic #(
      .STEPS (CORDIC_STEPS)
    ) u_cordic (
      .clk_i (clk_i),
      .en_i  (en),
      .z_i   (z_w[l]),
      .neg_i (neg_w[l]),
      .sin_o (sin_w[l]),
      .cos_o (cos_w[l])
    );
  end

  afsrt_mat u_mat (
    .clk_i   (clk_i),
    .en_i    (en),
    .sin_x_i (sin_w[0]),
    .cos_x_i (cos_w[0]),
    .sin_y_i (sin_w[1]),
    .cos_y_i (cos_w[1]),
    .sin_z_i (sin_w[2]),
    .cos_z_i (cos_w[2]),
    .scale_i (sc_dl_q[DLY-1]),
    .move_i  (mv_dl_q[DLY-1]),
    .mat_o   (mat)
  );

  afsrt_row_out u_row_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mat_valid_i (vld_q[LAT-1]),
    .mat_i       (mat),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .entry_0_o   (entry_0_o),
    .entry_1_o   (entry_1_o),
    .entry_2_o   (entry_2_o),
    .entry_3_o   (entry_3_o),
    .last_row_o  (last_row_o)
  );

`ifndef NO_ASSERTIONS
  // rows advance one at a time within a matrix
  a_row_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_row_o) |=>
      (out_valid_o && row_index_o == $past(row_index_o) + 2'd1))
    else $error("row index did not advance by one");

  // with nothing behind it, the last row drains the output
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_row_o && !vld_q[LAT-1]) |=> !out_valid_o)
    else $error("output stayed valid after the final row");

  // a finished matrix that is not taken holds in the last stage
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && !take) |=> (vld_q[LAT-1] && $stable(mat)))
    else $error("waiting matrix changed or was lost");

  a_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_row_o) |-> (entry_3_o == ONE_Q16))
    else $error("translation row lacks the unit entry");
`endif

endmodule

/* rtl/afsrt_angle_red.sv */
// ----------------------------------------------------------------------------
// afsrt_angle_red : four-stage angle reduction
// Reduces a Q16.16 angle modulo 2*pi into [-pi/2, pi/2] plus a negate flag.
// ----------------------------------------------------------------------------
module afsrt_angle_red
  import afsrt_pkg::*;
(
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [Q_W-1:0] angle_i,
  output cd_t            z_o,
  output logic           neg_o
);

  localparam logic [18:0] TWO_PI     = 19'd411775;
  localparam logic [63:0] RECIP_FULL = (64'd1 << 50) / 64'd411775;
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam logic [63:0] OFS_FULL   = (64'd1 << 31) % 64'd411775;
  localparam logic [18:0] OFS        = OFS_FULL[18:0];
  localparam int          RSH        = 50;
  localparam int          QB         = 14;

  localparam logic signed [19:0] TP_S   = 20'sd411775;
  localparam logic signed [19:0] PI_S   = 20'sd205887;
  localparam logic signed [19:0] HALF_S = 20'sd102944;

  logic [31:0] u_d, u1_q, u2_q;
  logic [63:0] prod_q;
  logic [32:0] qp_d, qp_q, diff;
  logic [18:0] rem_d, rem_q;
  logic signed [19:0] r0, r1, r2, r3;
  logic        neg_d;
  cd_t         z_d;

  always_comb begin
    // offset binary: u = angle + 2^31, then correct by 2^31 mod 2*pi
    u_d   = {~angle_i[Q_W-1], angle_i[Q_W-2:0]};
    qp_d  = 33'(prod_q[RSH +: QB]) * 33'(TWO_PI);
    diff  = {1'b0, u2_q} - qp_q;
    rem_d = (diff >= 33'(TWO_PI)) ? 19'(diff - 33'(TWO_PI)) : diff[18:0];

    r0 = $signed({1'b0, rem_q}) - $signed({1'b0, OFS});
    r1 = r0[19] ? r0 + TP_S : r0;
    r2 = (r1 > PI_S) ? r1 - TP_S : r1;
    if (r2 > HALF_S) begin
      r3    = r2 - PI_S;
      neg_d = 1'b1;
    end else if (r2 < -HALF_S) begin
      r3    = r2 + PI_S;
      neg_d = 1'b1;
    end else begin
      r3    = r2;
      neg_d = 1'b0;
    end
    z_d = $signed({r3, 14'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q   <= u_d;
      prod_q <= 64'(u_d) * 64'(RECIP);
      u2_q   <= u1_q;
      qp_q   <= qp_d;
      rem_q  <= rem_d;
      z_o    <= z_d;
      neg_o  <= neg_d;
    end
  end

endmodule

/* rtl/afsrt_cordic.sv */
// ----------------------------------------------------------------------------
// afsrt_cordic : pipelined rotation-mode CORDIC
// One micro-rotation per stage, then a rounding stage to Q2.16 sine/cosine.
// ----------------------------------------------------------------------------
module afsrt_cordic
  import afsrt_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  cd_t   z_i,
  input  logic  neg_i,
  output trig_t sin_o,
  output trig_t cos_o
);

  localparam cd_t GAIN = 34'sd652032874;

  cd_t  x_q [STEPS];
  cd_t  y_q [STEPS];
  cd_t  z_q [STEPS];
  logic neg_q [STEPS];

  // advance every micro-rotation stage together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STEPS; k++) begin
        cd_t  xi, yi, zi;
        logic ni;
        if (k == 0) begin
          xi = GAIN;
          yi = '0;
          zi = z_i;
          ni = neg_i;
        end else begin
          xi = x_q[k-1];
          yi = y_q[k-1];
          zi = z_q[k-1];
          ni = neg_q[k-1];
        end
        if (!zi[CD_W-1]) begin
          x_q[k] <= xi - (yi >>> k);
          y_q[k] <= yi + (xi >>> k);
          z_q[k] <= zi - atan_q30(k);
        end else begin
          x_q[k] <= xi + (yi >>> k);
          y_q[k] <= yi - (xi >>> k);
          z_q[k] <= zi + atan_q30(k);
        end
        neg_q[k] <= ni;
      end
    end
  end

  cd_t   xs, ys;
  trig_t cos_d, sin_d;

  always_comb begin
    xs    = (x_q[STEPS-1] + cd_t'(8192)) >>> 14;
    ys    = (y_q[STEPS-1] + cd_t'(8192)) >>> 14;
    cos_d = neg_q[STEPS-1] ? -xs[SC_W-1:0] : xs[SC_W-1:0];
    sin_d = neg_q[STEPS-1] ? -ys[SC_W-1:0] : ys[SC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end

endmodule

/* rtl/afsrt_mat.sv */
// ----------------------------------------------------------------------------
// afsrt_mat : three-stage matrix assembly
// Ry*Rz, then Rx times that, then the per-row scale with saturation.
// ----------------------------------------------------------------------------
module afsrt_mat
  import afsrt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  trig_t                sin_x_i,
  input  trig_t                cos_x_i,
  input  trig_t                sin_y_i,
  input  trig_t                cos_y_i,
  input  trig_t                sin_z_i,
  input  trig_t                cos_z_i,
  input  logic [2:0][Q_W-1:0]  scale_i,
  input  logic [2:0][Q_W-1:0]  move_i,
  output mat_t                 mat_o
);

  localparam int MW = SC_W + 2;
  localparam logic signed [47:0] MAXV = 48'sd2147483647;
  localparam logic signed [47:0] MINV = -48'sd2147483648;

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return t[47:0];
  endfunction

  function automatic trig_t mr1(input trig_t a, input trig_t b);
    logic signed [2*SC_W-1:0] p;
    logic signed [47:0]       r;
    p = a * b;
    r = rnd16(64'(p));
    return r[SC_W-1:0];
  endfunction

  function automatic logic signed [SC_W:0] mr2(input logic signed [SC_W:0] a,
                                               input trig_t b);
    logic signed [2*SC_W:0] p;
    logic signed [47:0]     r;
    p = a * b;
    r = rnd16(64'(p));
    return r[SC_W:0];
  endfunction

  trig_t a_d [3][3];
  trig_t a_q [3][3];
  logic signed [MW-1:0] b_d [3][3];
  logic signed [MW-1:0] b_q [3][3];
  logic [Q_W-1:0] f_d [3][3];
  logic [Q_W-1:0] f_q [3][3];
  trig_t cx1_q, sx1_q;
  logic signed [SC_W:0] nsx;
  logic [2:0][Q_W-1:0] s1_q, s2_q, m1_q, m2_q, m3_q;

  always_comb begin
    a_d[0][0] = mr1(cos_y_i, cos_z_i);
    a_d[0][1] = mr1(cos_y_i, sin_z_i);
    a_d[0][2] = -sin_y_i;
    a_d[1][0] = -sin_z_i;
    a_d[1][1] = cos_z_i;
    a_d[1][2] = '0;
    a_d[2][0] = mr1(sin_y_i, cos_z_i);
    a_d[2][1] = mr1(sin_y_i, sin_z_i);
    a_d[2][2] = cos_y_i;

    nsx = -(SC_W+1)'(sx1_q);
    for (int j = 0; j < 3; j++) begin
      b_d[0][j] = MW'(a_q[0][j]);
      b_d[1][j] = MW'(mr2((SC_W+1)'(cx1_q), a_q[1][j])) +
                  MW'(mr2((SC_W+1)'(sx1_q), a_q[2][j]));
      b_d[2][j] = MW'(mr2(nsx, a_q[1][j])) +
                  MW'(mr2((SC_W+1)'(cx1_q), a_q[2][j]));
    end
  end

  always_comb begin
    logic signed [Q_W+MW-1:0] p;
    logic signed [47:0]       v;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        p = $signed(s2_q[r]) * b_q[r][j];
        v = rnd16(64'(p));
        if (v > MAXV) begin
          f_d[r][j] = MAXV[Q_W-1:0];
        end else if (v < MINV) begin
          f_d[r][j] = MINV[Q_W-1:0];
        end else begin
          f_d[r][j] = v[Q_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      cx1_q <= cos_x_i;
      sx1_q <= sin_x_i;
      s1_q  <= scale_i;
      m1_q  <= move_i;
      b_q   <= b_d;
      s2_q  <= s1_q;
      m2_q  <= m1_q;
      f_q   <= f_d;
      m3_q  <= m2_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        mat_o.rot[r][j] = f_q[r][j];
      end
    end
    mat_o.mv = m3_q;
  end

endmodule

/* rtl/afsrt_row_out.sv */
// ----------------------------------------------------------------------------
// afsrt_row_out : matrix buffer and row sequencer
// Holds one finished matrix and hands it out one row per transaction.
// ----------------------------------------------------------------------------
module afsrt_row_out
  import afsrt_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mat_valid_i,
  input  mat_t           mat_i,
  output logic           take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     row_index_o,
  output logic [Q_W-1:0] entry_0_o,
  output logic [Q_W-1:0] entry_1_o,
  output logic [Q_W-1:0] entry_2_o,
  output logic [Q_W-1:0] entry_3_o,
  output logic           last_row_o
);

  mat_t       buf_q;
  logic       busy_q, busy_d;
  logic [1:0] row_q, row_d;
  logic       fire;

  always_comb begin
    fire   = busy_q && !out_stall_i;
    take_o = !busy_q || (fire && row_q == LAST_ROW);
    row_d  = fire ? row_q + 2'd1 : row_q;
    busy_d = take_o ? mat_valid_i : busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      buf_q <= mat_i;
    end
  end

  always_comb begin
    out_valid_o = busy_q;
    row_index_o = row_q;
    last_row_o  = (row_q == LAST_ROW);
    if (row_q == LAST_ROW) begin
      entry_0_o = buf_q.mv[0];
      entry_1_o = buf_q.mv[1];
      entry_2_o = buf_q.mv[2];
      entry_3_o = ONE_Q16;
    end else begin
      entry_0_o = buf_q.rot[row_q][0];
      entry_1_o = buf_q.rot[row_q][1];
      entry_2_o = buf_q.rot[row_q][2];
      entry_3_o = '0;
    end
  end

endmodule

/* tb/sv/affine_srt_matrix_builder_unit_tb.sv */
// ----------------------------------------------------------------------------
// affine_srt_matrix_builder_unit_tb : self-checking bench of the matrix builder
// Drives scale, Euler-angle and translation transactions, predicts the four
// Q16.16 rows of S * Rx * Ry * Rz * T with its own CORDIC and matrix product,
// and checks every output row in order under random idling and stalling.
// ----------------------------------------------------------------------------
module affine_srt_matrix_builder_unit_tb;
  import afsrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS        = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam longint TWO_PI   = 411775;
  localparam longint PI       = 205887;
  localparam longint HALF_PI  = 102944;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint ARCTAN_Q30 [10] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149
  };

  // one pending input transaction; hold_drain makes the sender wait for an
  // empty result store before presenting it
  typedef struct {
    logic [8:0][31:0] fld;
    bit               hold_drain;
  } xform_item_t;

  typedef struct {
    logic [1:0]       row;
    logic [3:0][31:0] ent;
    logic             last;
  } matrix_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, last_row_o;
  logic [Q_W-1:0] scale_x_i, scale_y_i, scale_z_i, angle_x_i, angle_y_i, angle_z_i;
  logic [Q_W-1:0] move_x_i, move_y_i, move_z_i;
  logic [1:0] row_index_o;
  logic [Q_W-1:0] entry_0_o, entry_1_o, entry_2_o, entry_3_o;

  xform_item_t pending_q[$];
  matrix_row_t matrix_rows_q[$];
  int          n_sent, errors, idle_cycles;
  int          tx_idle_pct, rx_idle_pct;

  affine_srt_matrix_builder_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // ---- prediction -----------------------------------------------------------

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctan_step(input int i);
    if (i < 10) return ARCTAN_Q30[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  // reduce the angle into [-pi/2, pi/2], rotate, round Q2.30 down to Q16.16
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint r, x, y, z, nx;
    bit flip;
    r = ang % TWO_PI;
    flip = 0;
    if (r < 0) r += TWO_PI;
    if (r > PI) r -= TWO_PI;
    if (r > HALF_PI) begin
      r -= PI; flip = 1;
    end else if (r < -HALF_PI) begin
      r += PI; flip = 1;
    end
    x = GAIN_Q30; y = 0; z = r * 16384;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step(i);
      end
      x = nx;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  // a = a * b with per-term rounding and a saturated sum
  task automatic mat_product(inout longint a[4][4], input longint b[4][4]);
    longint t[4][4];
    longint acc;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += (a[r][k] * b[k][c] + 32768) >>> 16;
        t[r][c] = sat_q16(acc);
      end
    a = t;
  endtask

  task automatic unit_matrix(output longint m[4][4]);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? longint'(ONE_Q16) : 0;
  endtask

  task automatic predict_rows(input logic [8:0][31:0] f);
    longint sm[4][4], rx[4][4], ry[4][4], rz[4][4], tm[4][4];
    longint s, c;
    matrix_row_t row;
    unit_matrix(sm); unit_matrix(rx); unit_matrix(ry); unit_matrix(rz); unit_matrix(tm);
    for (int a = 0; a < 3; a++) begin
      sm[a][a] = longint'($signed(f[a]));
      tm[3][a] = longint'($signed(f[6+a]));
    end
    sin_cos(longint'($signed(f[3])), s, c);
    rx[1][1] = c; rx[1][2] = s; rx[2][1] = -s; rx[2][2] = c;
    sin_cos(longint'($signed(f[4])), s, c);
    ry[0][0] = c; ry[0][2] = -s; ry[2][0] = s; ry[2][2] = c;
    sin_cos(longint'($signed(f[5])), s, c);
    rz[0][0] = c; rz[0][1] = s; rz[1][0] = -s; rz[1][1] = c;
    mat_product(ry, rz);
    mat_product(rx, ry);
    mat_product(rx, tm);
    mat_product(sm, rx);
    for (int r = 0; r < 4; r++) begin
      row.row = 2'(r);
      for (int j = 0; j < 4; j++) row.ent[j] = sm[r][j][31:0];
      row.last = (2'(r) == LAST_ROW);
      matrix_rows_q.push_back(row);
    end
  endtask

  // ---- driver -----------------------------------------------------------------

  // idling schedule: sender light / receiver heavy, then swapped, then none
  always_comb begin
    if (n_sent < 120) begin
      tx_idle_pct = 24; rx_idle_pct = 55;
    end else if (n_sent < 240) begin
      tx_idle_pct = 55; rx_idle_pct = 24;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    xform_item_t nxt;
    bit          free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      n_sent     <= 0;
    end else begin
      free = !in_valid_i || !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_rows({move_z_i, move_y_i, move_x_i, angle_z_i, angle_y_i, angle_x_i,
                      scale_z_i, scale_y_i, scale_x_i});
        n_sent <= n_sent + 1;
      end
      // hold a stalled transaction; otherwise advance or idle
      if (free) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
            !(pending_q[0].hold_drain && (matrix_rows_q.size() != 0 ||
              (in_valid_i && !in_stall_o)))) begin
          nxt = pending_q.pop_front();
          {move_z_i, move_y_i, move_x_i, angle_z_i, angle_y_i, angle_x_i,
           scale_z_i, scale_y_i, scale_x_i} <= nxt.fld;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    matrix_row_t      want;
    logic [3:0][31:0] got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (matrix_rows_q.size() == 0) begin
          $display("%0t: unexpected row %0d", $time, row_index_o);
          errors++;
        end else begin
          want = matrix_rows_q.pop_front();
          got  = {entry_3_o, entry_2_o, entry_1_o, entry_0_o};
          if (row_index_o !== want.row) begin
            $display("%0t: row_index expected %0d actual %0d", $time, want.row, row_index_o);
            errors++;
          end
          if (last_row_o !== want.last) begin
            $display("%0t: last_row expected %0b actual %0b", $time, want.last, last_row_o);
            errors++;
          end
          foreach (want.ent[j]) begin
            if (got[j] !== want.ent[j]) begin
              $display("%0t: row %0d entry_%0d expected %h actual %h", $time, want.row, j,
                       want.ent[j], got[j]);
              errors++;
            end
          end
        end
      end
      // watchdog: count cycles with no transaction on either side
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("affine_srt_matrix_builder_unit regression: fail");
        $finish;
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------------

  task automatic queue_item(input logic [8:0][31:0] f, input bit drain = 0);
    xform_item_t it;
    it.fld = f;
    it.hold_drain = drain;
    pending_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(823550)) - 411775);
      1: return 32'($signed($urandom_range(2000)) - 1000 +
                    ($urandom_range(1) ? 102944 : -102944));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [8:0][31:0] f;
    logic [31:0] edge_ang [10];
    errors = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    {scale_x_i, scale_y_i, scale_z_i, angle_x_i, angle_y_i, angle_z_i,
     move_x_i, move_y_i, move_z_i} = '0;

    // directed: identities, field extremes, angle reduction boundaries
    edge_ang = '{32'd102944, 32'd102945, -32'sd102944, -32'sd102945, 32'd205887,
                 32'd205888, 32'd411775, -32'sd205888, 32'h8000_0000, 32'h7fff_ffff};
    queue_item('0);
    queue_item({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, {3{32'(ONE_Q16)}}});
    queue_item({{3{32'h7fff_ffff}}, 32'd0, 32'd0, 32'd0, {3{32'h7fff_ffff}}});
    queue_item({{3{32'h8000_0000}}, 32'd0, 32'd0, 32'd0, {3{32'h8000_0000}}});
    queue_item({{3{32'hffff_ffff}}, {3{32'hffff_ffff}}, {3{32'hffff_ffff}}});
    queue_item({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h8000_0000}}});
    foreach (edge_ang[i])
      queue_item({32'd131072, -32'sd65536, 32'd98304, edge_ang[i], edge_ang[(i+3)%10],
                  edge_ang[(i+7)%10], 32'd65536, 32'd131072, 32'd196608});
    queue_item({$urandom(), $urandom(), $urandom(), 32'd51472, 32'd51472, 32'd51472,
                {3{32'h7fff_0000}}}, 1'b1);
    for (int i = 0; i < 330; i++) begin
      if ($urandom_range(9) < 7) begin
        // plausible transforms: moderate scale and translation, any angle
        for (int a = 0; a < 3; a++) begin
          f[a]   = 32'($signed($urandom_range(1048576)) - 524288);
          f[3+a] = pick_angle();
          f[6+a] = 32'($signed($urandom_range(33554432)) - 16777216);
        end
      end else begin
        for (int a = 0; a < 9; a++) f[a] = $urandom();
      end
      queue_item(f, (i % 110) == 60);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || matrix_rows_q.size() != 0);
    repeat (STEPS + 24) @(posedge clk_i);
    if (errors == 0) $display("affine_srt_matrix_builder_unit regression: pass");
    else $display("affine_srt_matrix_builder_unit regression: fail");
    $finish;
  end

endmodule
